[hdl/tpgb_pkg.sv]
// Shared constants, request and status codes, and slot bank types for the pulse generator bank.
package tpgb_pkg;

	localparam int DEF_NUM_SLOTS = 10;
	localparam int IDX_W         = 4;
	localparam int REQ_W         = 3;
	localparam int FREQ_W        = 24;
	localparam int TIME_W        = 48;
	localparam int CPU_W         = 32;
	localparam int STAT_W        = 2;
	localparam int DIV_W         = 48;

	localparam int IN_FIELDS_W  = IDX_W + FREQ_W + TIME_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STAT_W + IDX_W + 1 + FREQ_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CPU_W-1:0] CPU_FREQ_RST = CPU_W'(1000000);

	localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RESET   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SAMPLE  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_READ    = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_IDX = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd2;
	localparam logic [STAT_W-1:0] ST_ZERO    = 2'd3;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic              wr_freq;
		logic [FREQ_W-1:0] freq;
		logic              wr_anchor;
		logic [TIME_W-1:0] anchor;
		logic              wr_level;
		logic              level;
	} slot_wr_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [TIME_W-1:0] anchor;
		logic              level;
	} slot_rd_t;

endpackage

[hdl/timer_pulse_generator_bank_core.sv]
// Top level of the square-wave pulse generator bank: stream ports, request sequencer, divider.
// Each accepted word is decoded and its result registered; a valid sample of an active slot
// also makes two passes of the bit-serial divider (half period, then toggle count) between
// decode and result.
// Throughput: one request at a time; a new word is taken as soon as the previous one is retired.
// Reset clears every slot to free, unanchored and low, and sets cpu_frequency to 1000000.
module timer_pulse_generator_bank_core #(
	parameter int NUM_SLOTS = tpgb_pkg::DEF_NUM_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [tpgb_pkg::CPU_W-1:0]        cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [3:0] slot_index, [27:4] pulse_frequency, [75:28] now_cycles, rest zero
	input  logic [tpgb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [2:0] req_type
	input  logic [tpgb_pkg::REQ_W-1:0]        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [1:0] status, [5:2] granted_slot, [6] pulse_level, [30:7] frequency_readback, rest zero
	output logic [tpgb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import tpgb_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DEC, S_DIV1, S_DIV2, S_FIN} state_t;

	state_t            state_q;
	logic [CPU_W-1:0]  cpu_q;
	logic [REQ_W-1:0]  req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [FREQ_W-1:0] freq_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] delta_q;
	logic              lvl_q;
	slot_wr_t          wr_q;
	logic [STAT_W-1:0] st_q;
	logic [IDX_W-1:0]  gr_q;
	logic              olvl_q;
	logic [FREQ_W-1:0] rb_q;
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	slot_wr_t          slot_wr;
	slot_rd_t          rd;
	logic              free_found;
	logic [IDX_W-1:0]  free_idx;

	logic              div_start;
	logic [DIV_W-1:0]  div_a;
	logic [DIV_W-1:0]  div_b;
	logic              div_done;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  div_r;
	logic [DIV_W-1:0]  half;

	logic              idx_ok;
	logic              dec_div;
	logic [STAT_W-1:0] dec_st;
	logic [IDX_W-1:0]  dec_gr;
	logic              dec_lvl;
	logic [FREQ_W-1:0] dec_rb;
	slot_wr_t          dec_wr;
	logic [TIME_W-1:0] anchor_eff;
	logic              fin_fire;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign fin_fire      = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

	always_comb begin
		slot_wr    = wr_q;
		slot_wr.en = wr_q.en && fin_fire;
	end

	tpgb_slots #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (slot_wr),
		.rd_idx    (idx_q),
		.rd        (rd),
		.free_found(free_found),
		.free_idx  (free_idx)
	);

	// Half period is (cpu / freq) / 2 with a floor of one.
	assign half = (div_q[DIV_W-1:1] == '0) ? DIV_W'(1) : {1'b0, div_q[DIV_W-1:1]};

	assign div_start = ((state_q == S_DEC) && dec_div) || ((state_q == S_DIV1) && div_done);
	assign div_a     = (state_q == S_DEC) ? DIV_W'(cpu_q) : DIV_W'(delta_q);
	assign div_b     = (state_q == S_DEC) ? DIV_W'(rd.freq) : half;

	tpgb_div #(
		.W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q),
		.remainder(div_r)
	);

	assign idx_ok     = {1'b0, idx_q} < (IDX_W + 1)'(NUM_SLOTS);
	assign anchor_eff = (rd.anchor == '0) ? now_q : rd.anchor;

	always_comb begin
		dec_div = 1'b0;
		dec_st  = ST_OK;
		dec_gr  = idx_q;
		dec_lvl = 1'b0;
		dec_rb  = '0;
		dec_wr  = '0;
		dec_wr.idx = idx_q;
		if (req_q == REQ_ALLOC) begin
			dec_gr = '0;
			if (freq_q == '0) begin
				dec_st = ST_ZERO;
			end else if (!free_found) begin
				dec_st = ST_NO_FREE;
			end else begin
				dec_gr           = free_idx;
				dec_wr.en        = 1'b1;
				dec_wr.idx       = free_idx;
				dec_wr.wr_freq   = 1'b1;
				dec_wr.freq      = freq_q;
				dec_wr.wr_anchor = 1'b1;
				dec_wr.anchor    = now_q;
			end
		end else if (req_q == REQ_RELEASE || req_q == REQ_SET || req_q == REQ_RESET ||
				req_q == REQ_SAMPLE || req_q == REQ_READ) begin
			if (!idx_ok) begin
				dec_st = ST_BAD_IDX;
			end else begin
				unique case (req_q)
					REQ_RELEASE: begin
						dec_wr.en        = 1'b1;
						dec_wr.wr_freq   = 1'b1;
						dec_wr.wr_anchor = 1'b1;
					end
					REQ_SET: begin
						if (freq_q == '0) begin
							dec_st = ST_ZERO;
						end else begin
							dec_wr.en        = 1'b1;
							dec_wr.wr_freq   = 1'b1;
							dec_wr.freq      = freq_q;
							dec_wr.wr_anchor = 1'b1;
							dec_wr.anchor    = now_q;
						end
					end
					REQ_RESET: begin
						dec_wr.en        = 1'b1;
						dec_wr.wr_anchor = 1'b1;
						dec_wr.wr_level  = 1'b1;
					end
					REQ_SAMPLE: begin
						dec_lvl = rd.level;
						if (rd.freq == '0)
							dec_st = ST_ZERO;
						else
							dec_div = 1'b1;
					end
					default: begin
						dec_rb = rd.freq;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cpu_q     <= CPU_FREQ_RST;
			m_valid_q <= 1'b0;
			wr_q      <= '0;
		end else begin
			if (cfg_wen)
				cpu_q <= cfg_wdata;
			if (m_valid_q && m_axis_tready && !fin_fire)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_DEC;
				end
				S_DEC: begin
					st_q   <= dec_st;
					gr_q   <= dec_gr;
					olvl_q <= dec_lvl;
					rb_q   <= dec_rb;
					wr_q   <= dec_wr;
					// The elapsed time is measured from the stored anchor (or from now if unanchored) before the anchor is replaced.
					delta_q <= now_q - anchor_eff;
					lvl_q   <= rd.level;
					state_q <= dec_div ? S_DIV1 : S_FIN;
				end
				S_DIV1: begin
					if (div_done)
						state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						// Anchor advanced by whole half periods lands at now minus the remainder.
						wr_q.en        <= 1'b1;
						wr_q.wr_anchor <= 1'b1;
						wr_q.anchor    <= now_q - div_r;
						wr_q.wr_level  <= 1'b1;
						wr_q.level     <= lvl_q ^ div_q[0];
						olvl_q         <= lvl_q ^ div_q[0];
						state_q        <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						m_valid_q <= 1'b1;
						m_data_q  <= OUT_DATA_W'({rb_q, olvl_q, gr_q, st_q});
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q  <= s_axis_tuser;
			idx_q  <= s_axis_tdata[IDX_W-1:0];
			freq_q <= s_axis_tdata[IDX_W +: FREQ_W];
			now_q  <= s_axis_tdata[IDX_W + FREQ_W +: TIME_W];
		end
	end

endmodule

[hdl/tpgb_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, shared by both divisions.
module tpgb_div #(
	parameter int W = tpgb_pkg::DIV_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;
	logic [W:0]       diff;

	// The dividend shifts out of the top of quo_q while quotient bits shift in below.
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (diff[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end else begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hdl/tpgb_slots.sv]
// Slot register bank: frequency, phase anchor and level per slot, with lowest-free-slot search.
module tpgb_slots #(
	parameter int NUM_SLOTS = tpgb_pkg::DEF_NUM_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpgb_pkg::slot_wr_t          wr,
	input  logic [tpgb_pkg::IDX_W-1:0]  rd_idx,
	output tpgb_pkg::slot_rd_t          rd,
	output logic                        free_found,
	output logic [tpgb_pkg::IDX_W-1:0]  free_idx
);
	import tpgb_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [FREQ_W-1:0] freq_q   [NUM_SLOTS];
	logic [TIME_W-1:0] anchor_q [NUM_SLOTS];
	logic              level_q  [NUM_SLOTS];
	logic [SLOT_W-1:0] wsel;
	logic [SLOT_W-1:0] rsel;

	assign wsel = wr.idx[SLOT_W-1:0];
	assign rsel = rd_idx[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				freq_q[i]   <= '0;
				anchor_q[i] <= '0;
				level_q[i]  <= 1'b0;
			end
		end else if (wr.en) begin
			if (wr.wr_freq)
				freq_q[wsel] <= wr.freq;
			if (wr.wr_anchor)
				anchor_q[wsel] <= wr.anchor;
			if (wr.wr_level)
				level_q[wsel] <= wr.level;
		end
	end

	// Only meaningful when rd_idx is below NUM_SLOTS; the controller checks that.
	assign rd.freq   = freq_q[rsel];
	assign rd.anchor = anchor_q[rsel];
	assign rd.level  = level_q[rsel];

	// A slot is free while its frequency is zero; the lowest free one wins.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (freq_q[i] == '0) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

endmodule
